FILE: rtl/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants for the searchable LIFO stack.
// ----------------------------------------------------------------------------
package lss_pkg;

   // Stack geometry.
   localparam int DEPTH  = 16;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int POS_W  = 4;

   // Command codes.
   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_FIRST = 2'd2;
   localparam logic [1:0] CMD_LAST  = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_SEARCH
   } state_type;

   // Write port request.
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } wr_req_type;

   // Read port request.
   typedef struct packed {
      logic              re;
      logic [ADDR_W-1:0] addr;
   } rd_req_type;

endpackage

FILE: rtl/lss_ram.sv
// ----------------------------------------------------------------------------
// lss_ram
// Entry storage: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module lss_ram (
   input  logic                      clock,
   input  lss_pkg::wr_req_type       wr,
   input  lss_pkg::rd_req_type       rd,
   output logic [lss_pkg::WORD_W-1:0] rd_data
);

   logic [lss_pkg::WORD_W-1:0] mem [lss_pkg::DEPTH];
   logic [lss_pkg::WORD_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd.re) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lifo_stack_with_search.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Bounded LIFO stack of 32-bit words with first-match and last-match search.
// ----------------------------------------------------------------------------
// Usage: present req_cmd and req_value with start high; the command is taken
// at a rising edge where busy is low. Every command gives exactly one word on
// rsp_status, rsp_data and rsp_position, marked by rsp_valid for one cycle.
// The receiver cannot stall; results are shown once and must be taken.
// Timing by command:
//   Push (or any command on a full/empty stack that needs no read): result
//   in the cycle after acceptance, busy stays low, so one command per cycle.
//   Pop: one read of the entry memory; the word passes the memory's read
//   register and then the result register, with busy high in between.
//   Search: the entry memory is read one entry per cycle from the top, down
//   to the bottom entry at most; a first-match search ends at the first hit.
// The next command may be accepted in the cycle the result is shown.
// Reset clears the fill count and the controller; the entries themselves
// are not cleared, which needs no pass since only written entries are read.
// ----------------------------------------------------------------------------
module lifo_stack_with_search (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_cmd,
   input  logic signed [31:0]         req_value,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_status,
   output logic signed [31:0]         rsp_data,
   output logic [3:0]                 rsp_position
);

   localparam int ADDR_W = lss_pkg::ADDR_W;
   localparam int CNT_W  = lss_pkg::CNT_W;
   localparam int WORD_W = lss_pkg::WORD_W;

   lss_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [WORD_W-1:0]  val_ff, val_in;
   logic               first_ff, first_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0]  scan_addr_ff, scan_addr_in;
   logic               found_ff, found_in;
   logic [ADDR_W-1:0]  hitpos_ff, hitpos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [3:0]         rsp_position_ff, rsp_position_in;

   lss_pkg::wr_req_type wr;
   lss_pkg::rd_req_type rd;
   logic [WORD_W-1:0]   rd_data;

   logic [CNT_W-1:0]  fill_dec;
   logic [ADDR_W-1:0] top_addr;
   logic              is_full;
   logic              is_empty;
   logic              hit;
   logic              last_entry;

   lss_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   // Fill level decode.
   assign fill_dec   = fill_ff - CNT_W'(1);
   assign top_addr   = fill_dec[ADDR_W-1:0];
   assign is_full    = (fill_ff == CNT_W'(lss_pkg::DEPTH));
   assign is_empty   = (fill_ff == '0);
   assign hit        = (rd_data == val_ff);
   assign last_entry = (scan_addr_ff == '0);

   // State and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lss_pkg::ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff          <= val_in;
      first_ff        <= first_in;
      idx_ff          <= idx_in;
      scan_addr_ff    <= scan_addr_in;
      found_ff        <= found_in;
      hitpos_ff       <= hitpos_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_position_ff <= rsp_position_in;
   end

   // Next state, memory requests and result word.
   always_comb begin
      state_in        = state_ff;
      fill_in         = fill_ff;
      val_in          = val_ff;
      first_in        = first_ff;
      idx_in          = idx_ff;
      scan_addr_in    = scan_addr_ff;
      found_in        = found_ff;
      hitpos_in       = hitpos_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = lss_pkg::ST_OK;
      rsp_data_in     = '0;
      rsp_position_in = '0;
      wr              = '0;
      rd              = '0;

      case (state_ff)
         lss_pkg::ST_IDLE: begin
            if (start) begin
               case (req_cmd)
                  lss_pkg::CMD_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        rsp_status_in = lss_pkg::ST_FULL;
                     end else begin
                        wr.we   = 1'b1;
                        wr.addr = fill_ff[ADDR_W-1:0];
                        wr.data = req_value;
                        fill_in = fill_ff + CNT_W'(1);
                     end
                  end
                  lss_pkg::CMD_POP: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = lss_pkg::ST_EMPTY;
                     end else begin
                        rd.re    = 1'b1;
                        rd.addr  = top_addr;
                        fill_in  = fill_dec;
                        state_in = lss_pkg::ST_POP_WAIT;
                     end
                  end
                  default: begin
                     // Both search commands start a scan from the top.
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = lss_pkg::ST_EMPTY;
                     end else begin
                        rd.re        = 1'b1;
                        rd.addr      = top_addr;
                        scan_addr_in = top_addr;
                        idx_in       = '0;
                        found_in     = 1'b0;
                        val_in       = req_value;
                        first_in     = (req_cmd == lss_pkg::CMD_FIRST);
                        state_in     = lss_pkg::ST_SEARCH;
                     end
                  end
               endcase
            end
         end
         lss_pkg::ST_POP_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = rd_data;
            state_in     = lss_pkg::ST_IDLE;
         end
         lss_pkg::ST_SEARCH: begin
            if ((hit && first_ff) || last_entry) begin
               // The scan ends here: report the newest hit or the stored one.
               rsp_valid_in = 1'b1;
               state_in     = lss_pkg::ST_IDLE;
               if (hit) begin
                  rsp_data_in     = val_ff;
                  rsp_position_in = 4'(idx_ff);
               end else if (found_ff) begin
                  rsp_data_in     = val_ff;
                  rsp_position_in = 4'(hitpos_ff);
               end else begin
                  rsp_status_in = lss_pkg::ST_EMPTY;
               end
            end else begin
               if (hit) begin
                  found_in  = 1'b1;
                  hitpos_in = idx_ff;
               end
               rd.re        = 1'b1;
               rd.addr      = scan_addr_ff - ADDR_W'(1);
               scan_addr_in = scan_addr_ff - ADDR_W'(1);
               idx_in       = idx_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = lss_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy         = (state_ff != lss_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_position = rsp_position_ff;

   // The fill count never passes the stack depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(lss_pkg::DEPTH))
      else $error("fill count exceeds depth");

   // A scan only runs over a stack that holds entries.
   a_search_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lss_pkg::ST_SEARCH) |-> !is_empty)
      else $error("search running on an empty stack");

   // No write may land while a pop or a scan is reading the memory.
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !wr.we)
      else $error("memory write while a read is outstanding");

   // An accepted push on a stack with room raises the fill count by one.
   a_push_fill: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == lss_pkg::CMD_PUSH) && !is_full)
      |=> (fill_ff == $past(fill_ff) + CNT_W'(1)))
      else $error("push did not advance the fill count");

   // A dropped push reports zero data and position.
   a_full_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == lss_pkg::ST_FULL))
      |-> ((rsp_data_ff == '0) && (rsp_position_ff == '0)))
      else $error("full response carries a payload");

endmodule
